### rtl/ipdfe_pkg.sv
// Shared constants, types and helpers for the IPD frame extractor.
package ipdfe_pkg;

  // Default elapsed-tick counter width
  localparam int TIMER_WIDTH_DEF = 32;

  // Item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DATA      = 2'd0;
  localparam logic [1:0] ST_NO_TAG    = 2'd1;
  localparam logic [1:0] ST_BAD_LEN   = 2'd2;
  localparam logic [1:0] ST_DATA_TOUT = 2'd3;

  // Receive phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TAG  = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  // Configuration register indexes
  localparam logic CFG_MAX_LEN = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  // Framing constants
  localparam logic [2:0]  TAG_LEN   = 3'd5;
  localparam logic [7:0]  CH_PLUS   = 8'h2B;
  localparam logic [7:0]  CH_I      = 8'h49;
  localparam logic [7:0]  CH_P      = 8'h50;
  localparam logic [7:0]  CH_D      = 8'h44;
  localparam logic [7:0]  CH_COMMA  = 8'h2C;
  localparam logic [7:0]  CH_COLON  = 8'h3A;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_NINE   = 8'h39;
  localparam logic [15:0] LEN_SAT   = 16'hFFFF;
  localparam logic [11:0] LEN_CAP   = 12'd2048;
  localparam logic [11:0] MAX_LEN_RST = 12'd2048;
  localparam logic [31:0] TIMEOUT_RST = 32'd1000;

  // Timer control from the parser
  typedef struct packed {
    logic clear;
    logic tick;
  } timer_ctrl_t;

  // Deadline flags back to the parser
  typedef struct packed {
    logic tag_expired;
    logic tick_tag_expired;
    logic tick_byte_expired;
  } timer_stat_t;

  // Expected character at each position of the tag
  function automatic logic [7:0] tag_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = CH_PLUS;
      3'd1:    ch = CH_I;
      3'd2:    ch = CH_P;
      3'd3:    ch = CH_D;
      default: ch = CH_COMMA;
    endcase
    return ch;
  endfunction

endpackage

### rtl/ipdfe_timer.sv
// Saturating elapsed-tick counter with search and per-byte deadline compares.
module ipdfe_timer #(
  parameter int TIMER_WIDTH = ipdfe_pkg::TIMER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ipdfe_pkg::timer_ctrl_t ctrl,
  input  logic [31:0]            timeout_ticks,
  output ipdfe_pkg::timer_stat_t stat
);

  localparam int CW = (TIMER_WIDTH > 32) ? TIMER_WIDTH : 32;

  logic [TIMER_WIDTH-1:0] elapsed;
  logic [TIMER_WIDTH-1:0] elapsed_inc;
  logic [CW-1:0]          tmask_cw;
  logic [CW-1:0]          timeout_cw;
  logic [CW-1:0]          byte_req;
  logic [CW-1:0]          tag_wait;
  logic [CW-1:0]          byte_wait;

  // Cap both waits at the largest count the counter holds
  assign tmask_cw   = CW'({TIMER_WIDTH{1'b1}});
  assign timeout_cw = CW'(timeout_ticks);
  assign byte_req   = (timeout_ticks == 32'd0) ? CW'(1) : timeout_cw;
  assign tag_wait   = (timeout_cw > tmask_cw) ? tmask_cw : timeout_cw;
  assign byte_wait  = (byte_req > tmask_cw) ? tmask_cw : byte_req;

  // Saturating increment
  assign elapsed_inc = (elapsed == {TIMER_WIDTH{1'b1}}) ? elapsed : elapsed + 1'b1;

  // Deadline flags, now and after this tick
  assign stat.tag_expired       = CW'(elapsed) >= tag_wait;
  assign stat.tick_tag_expired  = CW'(elapsed_inc) >= tag_wait;
  assign stat.tick_byte_expired = CW'(elapsed_inc) >= byte_wait;

  // Clear has priority over a tick
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (ctrl.clear) begin
      elapsed <= '0;
    end else if (ctrl.tick) begin
      elapsed <= elapsed_inc;
    end
  end

endmodule

### rtl/ipd_frame_extractor_core.sv
// Top level of the IPD frame extractor: tag search, length parse and payload output.
// One item (start, received byte or millisecond tick) is taken per cycle while item_ready
// is high; each item updates the parser state in the cycle it is transferred and yields at
// most one result, which sits in a single output register. item_ready is high whenever
// that register is empty or being taken in the same cycle, so the block sustains one item
// per cycle while the result side keeps up. Results appear in the cycle after their item.
module ipd_frame_extractor_core #(
  parameter int TIMER_WIDTH = ipdfe_pkg::TIMER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // Input items
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  rx_byte,
  // Results
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic [7:0]  data,
  output logic        last,
  output logic [11:0] delivered
);

  logic [11:0] max_len;
  logic [31:0] timeout_ticks;

  logic [1:0]  phase, phase_next;
  logic [2:0]  tag_matched, tag_matched_next;
  logic [15:0] length_accum, length_accum_next;
  logic [11:0] bytes_sent, bytes_sent_next;

  logic        accept;
  logic        emit;
  logic [1:0]  emit_status;
  logic [7:0]  emit_data;
  logic        emit_last;
  logic [11:0] emit_delivered;

  logic [11:0] len_limit;
  logic [15:0] len_clipped;
  logic [19:0] len_digit;
  logic [11:0] sent_inc;
  logic        is_digit;

  ipdfe_pkg::timer_ctrl_t timer_ctrl;
  ipdfe_pkg::timer_stat_t timer_stat;

  ipdfe_timer #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_timer (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (timer_ctrl),
    .timeout_ticks(timeout_ticks),
    .stat         (timer_stat)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len       <= ipdfe_pkg::MAX_LEN_RST;
      timeout_ticks <= ipdfe_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ipdfe_pkg::CFG_MAX_LEN: max_len       <= cfg_data[11:0];
        ipdfe_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  // Length clip for payload entry
  assign len_limit = (max_len == 12'd0) ? 12'd1 :
                     (max_len > ipdfe_pkg::LEN_CAP) ? ipdfe_pkg::LEN_CAP : max_len;
  assign len_clipped = (length_accum > {4'd0, len_limit}) ? {4'd0, len_limit} : length_accum;

  // Decimal accumulate: times ten plus digit
  assign is_digit  = (rx_byte >= ipdfe_pkg::CH_ZERO) && (rx_byte <= ipdfe_pkg::CH_NINE);
  assign len_digit = {1'b0, length_accum, 3'd0} + {3'd0, length_accum, 1'b0}
                   + {16'd0, rx_byte[3:0]};
  assign sent_inc  = bytes_sent + 12'd1;

  // Parser next state and result
  always_comb begin
    phase_next        = phase;
    tag_matched_next  = tag_matched;
    length_accum_next = length_accum;
    bytes_sent_next   = bytes_sent;
    timer_ctrl        = '0;
    emit              = 1'b0;
    emit_status       = ipdfe_pkg::ST_DATA;
    emit_data         = 8'd0;
    emit_last         = 1'b1;
    emit_delivered    = 12'd0;

    if (accept) begin
      case (kind)
        ipdfe_pkg::KIND_START: begin
          phase_next        = ipdfe_pkg::PH_TAG;
          tag_matched_next  = 3'd0;
          length_accum_next = 16'd0;
          bytes_sent_next   = 12'd0;
          timer_ctrl.clear  = 1'b1;
        end

        ipdfe_pkg::KIND_TICK: begin
          timer_ctrl.tick = (phase != ipdfe_pkg::PH_IDLE);
          case (phase)
            ipdfe_pkg::PH_TAG: begin
              if (timer_stat.tick_tag_expired) begin
                phase_next  = ipdfe_pkg::PH_IDLE;
                emit        = 1'b1;
                emit_status = ipdfe_pkg::ST_NO_TAG;
              end
            end
            ipdfe_pkg::PH_LEN: begin
              if (timer_stat.tick_byte_expired) begin
                if (length_accum != 16'd0) begin
                  // Length timed out with a nonzero length: go on to the payload
                  phase_next        = ipdfe_pkg::PH_DATA;
                  length_accum_next = len_clipped;
                  bytes_sent_next   = 12'd0;
                  timer_ctrl.clear  = 1'b1;
                end else begin
                  phase_next  = ipdfe_pkg::PH_IDLE;
                  emit        = 1'b1;
                  emit_status = ipdfe_pkg::ST_BAD_LEN;
                end
              end
            end
            ipdfe_pkg::PH_DATA: begin
              if (timer_stat.tick_byte_expired) begin
                phase_next     = ipdfe_pkg::PH_IDLE;
                emit           = 1'b1;
                emit_status    = ipdfe_pkg::ST_DATA_TOUT;
                emit_delivered = bytes_sent;
              end
            end
            default: ;
          endcase
        end

        ipdfe_pkg::KIND_BYTE: begin
          case (phase)
            ipdfe_pkg::PH_TAG: begin
              // Bytes after the search deadline are dropped
              if (!timer_stat.tag_expired) begin
                if (tag_matched < ipdfe_pkg::TAG_LEN &&
                    rx_byte == ipdfe_pkg::tag_char(tag_matched)) begin
                  tag_matched_next = tag_matched + 3'd1;
                  if (tag_matched == ipdfe_pkg::TAG_LEN - 3'd1) begin
                    phase_next        = ipdfe_pkg::PH_LEN;
                    length_accum_next = 16'd0;
                    timer_ctrl.clear  = 1'b1;
                  end
                end else begin
                  // A plus restarts the match at one
                  tag_matched_next = (rx_byte == ipdfe_pkg::CH_PLUS) ? 3'd1 : 3'd0;
                end
              end
            end
            ipdfe_pkg::PH_LEN: begin
              if (rx_byte == ipdfe_pkg::CH_COLON) begin
                if (length_accum == 16'd0) begin
                  phase_next  = ipdfe_pkg::PH_IDLE;
                  emit        = 1'b1;
                  emit_status = ipdfe_pkg::ST_BAD_LEN;
                end else begin
                  phase_next        = ipdfe_pkg::PH_DATA;
                  length_accum_next = len_clipped;
                  bytes_sent_next   = 12'd0;
                  timer_ctrl.clear  = 1'b1;
                end
              end else if (is_digit) begin
                length_accum_next = (len_digit > {4'd0, ipdfe_pkg::LEN_SAT}) ?
                                    ipdfe_pkg::LEN_SAT : len_digit[15:0];
                timer_ctrl.clear  = 1'b1;
              end else begin
                phase_next  = ipdfe_pkg::PH_IDLE;
                emit        = 1'b1;
                emit_status = ipdfe_pkg::ST_BAD_LEN;
              end
            end
            ipdfe_pkg::PH_DATA: begin
              bytes_sent_next  = sent_inc;
              timer_ctrl.clear = 1'b1;
              emit             = 1'b1;
              emit_status      = ipdfe_pkg::ST_DATA;
              emit_data        = rx_byte;
              if ({4'd0, sent_inc} >= length_accum) begin
                phase_next     = ipdfe_pkg::PH_IDLE;
                emit_last      = 1'b1;
                emit_delivered = sent_inc;
              end else begin
                emit_last = 1'b0;
              end
            end
            default: ;
          endcase
        end

        default: ;
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ipdfe_pkg::PH_IDLE;
      tag_matched  <= 3'd0;
      length_accum <= 16'd0;
      bytes_sent   <= 12'd0;
    end else begin
      phase        <= phase_next;
      tag_matched  <= tag_matched_next;
      length_accum <= length_accum_next;
      bytes_sent   <= bytes_sent_next;
    end
  end

  // Result register: load on a producing transfer, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      status    <= emit_status;
      data      <= emit_data;
      last      <= emit_last;
      delivered <= emit_delivered;
    end
  end

  // Checks
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ipdfe_pkg::ST_DATA |-> last && data == 8'd0)
    else $error("error result without last or with data");

  a_mid_byte_no_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> status == ipdfe_pkg::ST_DATA && delivered == 12'd0)
    else $error("non-final payload byte carries a count");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> delivered <= ipdfe_pkg::LEN_CAP)
    else $error("delivered count above cap");

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    accept && kind == ipdfe_pkg::KIND_START |=>
      phase == ipdfe_pkg::PH_TAG && tag_matched == 3'd0 && bytes_sent == 12'd0)
    else $error("start did not arm the tag search");

  a_payload_target: assert property (@(posedge clk) disable iff (rst)
    phase == ipdfe_pkg::PH_DATA |->
      length_accum != 16'd0 && length_accum <= {4'd0, ipdfe_pkg::LEN_CAP})
    else $error("payload target out of range");

endmodule
